>>> rtl/bpfa_pkg.sv
package bpfa_pkg;

    // page geometry
    localparam int PAGE_TOTAL     = 4096;
    localparam int RESERVED_PAGES = 1024;
    localparam int PAGE_BYTES     = 'h1000;

    // field widths
    localparam int PAGE_W  = 12;
    localparam int COUNT_W = 13;

    // used map layout, one bit per page, packed into words
    localparam int WORD_W    = 32;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int MAP_WORDS = (PAGE_TOTAL + WORD_W - 1) / WORD_W;
    localparam int WADDR_W   = $clog2(MAP_WORDS);
    localparam int RES_LIM   = (RESERVED_PAGES > PAGE_TOTAL) ? PAGE_TOTAL : RESERVED_PAGES;

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(PAGE_TOTAL);
    localparam logic [PAGE_W-1:0]  LAST_PAGE = PAGE_W'(PAGE_TOTAL - 1);

    typedef enum logic
    {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } func_t;

    // outcome of looking at one map word during a first-fit search
    typedef struct packed
    {
        logic               found;
        logic [PAGE_W-1:0]  start;
        logic [COUNT_W-1:0] run;
        logic [PAGE_W-1:0]  run_start;
    } scan_t;

    // contents of map word w right after reset
    function automatic logic [WORD_W-1:0] reset_word(logic [WADDR_W-1:0] w);
        int base;
        logic [WORD_W-1:0] val;
        base = int'(w) * WORD_W;
        if (base + WORD_W <= RES_LIM)
        begin
            val = '1;
        end
        else if (base >= RES_LIM)
        begin
            val = '0;
        end
        else
        begin
            val = {WORD_W{1'b1}} >> (WORD_W - (RES_LIM - base));
        end
        return val;
    endfunction

endpackage

>>> rtl/bpfa_req_if.sv
interface bpfa_req_if;
    import bpfa_pkg::*;

    logic               valid;
    logic               ready;
    logic               func;
    logic [COUNT_W-1:0] page_count;
    logic [PAGE_W-1:0]  first_page;

    modport source (output valid, output func, output page_count, output first_page,
                    input ready);
    modport sink   (input valid, input func, input page_count, input first_page,
                    output ready);
endinterface

>>> rtl/bpfa_rsp_if.sv
interface bpfa_rsp_if;
    import bpfa_pkg::*;

    logic              valid;
    logic              ready;
    logic              ok;
    logic [PAGE_W-1:0] start_page;

    modport source (output valid, output ok, output start_page, input ready);
    modport sink   (input valid, input ok, input start_page, output ready);
endinterface

>>> rtl/bitmap_page_frame_allocator_core.sv
// first-fit page frame allocator over a used bitmap of 4096 pages (4 KiB each),
// held 32 pages to a word in a 128-word single-port-read/single-port-write RAM.
// after reset the block writes the initial map (pages below the reserved count
// marked used) and keeps req.ready low meanwhile. it takes one request at a
// time: an allocate walks the map one word per cycle from word 0 until it finds
// the first run of page_count free pages, then read-modify-writes every word the
// run touches, one word per cycle; a free does the same read-modify-write over
// the words from first_page to the end of its range. every request yields
// exactly one response beat; a failed allocate (count 0, count above 4096, or
// no run long enough) returns ok = 0 and start_page = 0, a free always returns
// ok = 1.
module bitmap_page_frame_allocator_core (
    input  logic       clk,
    input  logic       rst_n,
    bpfa_req_if.sink   req,
    bpfa_rsp_if.source rsp
);
    import bpfa_pkg::*;

    typedef enum logic [2:0]
    {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;

    logic [WADDR_W-1:0] init_reg, init_next;
    logic               func_reg, func_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [WADDR_W:0]   iss_reg, iss_next;
    logic [WADDR_W-1:0] last_reg, last_next;
    logic               ev_valid_reg, ev_valid_next;
    logic [WADDR_W-1:0] ev_word_reg, ev_word_next;
    logic [PAGE_W-1:0]  lo_reg, lo_next;
    logic [PAGE_W-1:0]  hi_reg, hi_next;
    logic [COUNT_W-1:0] run_reg, run_next;
    logic [PAGE_W-1:0]  run_start_reg, run_start_next;
    logic               res_ok_reg, res_ok_next;
    logic [PAGE_W-1:0]  res_start_reg, res_start_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic               rsp_ok_reg, rsp_ok_next;
    logic [PAGE_W-1:0]  rsp_start_reg, rsp_start_next;

    // map memory ports
    logic               ram_we;
    logic [WADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [WADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;

    scan_t              scan;
    logic [COUNT_W:0]   free_end;
    logic [PAGE_W-1:0]  free_hi;
    logic [COUNT_W-1:0] alloc_end;
    logic [WORD_W-1:0]  lo_mask;
    logic [WORD_W-1:0]  hi_mask;
    logic [WORD_W-1:0]  range_mask;

    bpfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // first-fit evaluation of the word that just came out of the RAM
    bpfa_scan u_scan (
        .word         (ram_rdata),
        .word_idx     (ev_word_reg),
        .count        (count_reg),
        .run_in       (run_reg),
        .run_start_in (run_start_reg),
        .res          (scan)
    );

    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.ok         = rsp_ok_reg;
    assign rsp.start_page = rsp_start_reg;

    always_comb
    begin
        // last page of a free, clipped to the end of the map
        free_end = {2'b00, req.first_page} + {1'b0, req.page_count} - (COUNT_W+1)'(1);
        free_hi  = (free_end > (COUNT_W+1)'(LAST_PAGE)) ? LAST_PAGE
                                                         : free_end[PAGE_W-1:0];
        alloc_end = {1'b0, scan.start} + count_reg - COUNT_W'(1);

        // pages of the current word that fall inside [lo, hi]
        lo_mask = (ev_word_reg == lo_reg[PAGE_W-1:BIT_W])
                  ? ({WORD_W{1'b1}} << lo_reg[BIT_W-1:0]) : '1;
        hi_mask = (ev_word_reg == hi_reg[PAGE_W-1:BIT_W])
                  ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi_reg[BIT_W-1:0])) : '1;
        range_mask = lo_mask & hi_mask;
    end

    always_comb
    begin
        state_next     = state_reg;
        init_next      = init_reg;
        func_next      = func_reg;
        count_next     = count_reg;
        iss_next       = iss_reg;
        last_next      = last_reg;
        ev_valid_next  = ev_valid_reg;
        ev_word_next   = ev_word_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        run_next       = run_reg;
        run_start_next = run_start_reg;
        res_ok_next    = res_ok_reg;
        res_start_next = res_start_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_ok_next    = rsp_ok_reg;
        rsp_start_next = rsp_start_reg;

        ram_we    = 1'b0;
        ram_waddr = ev_word_reg;
        ram_wdata = (func_reg == FUNC_FREE) ? (ram_rdata & ~range_mask)
                                            : (ram_rdata | range_mask);
        ram_raddr = iss_reg[WADDR_W-1:0];

        // response beat taken
        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                // one word of the initial map per cycle
                ram_we    = 1'b1;
                ram_waddr = init_reg;
                ram_wdata = reset_word(init_reg);
                init_next = init_reg + WADDR_W'(1);
                if (init_reg == WADDR_W'(MAP_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    func_next      = req.func;
                    count_next     = req.page_count;
                    res_start_next = '0;
                    ev_valid_next  = 1'b0;
                    if (req.func == FUNC_FREE)
                    begin
                        res_ok_next = 1'b1;
                        if (req.page_count == '0)
                        begin
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            lo_next    = req.first_page;
                            hi_next    = free_hi;
                            iss_next   = {1'b0, req.first_page[PAGE_W-1:BIT_W]};
                            last_next  = free_hi[PAGE_W-1:BIT_W];
                            state_next = ST_MARK;
                        end
                    end
                    else
                    begin
                        res_ok_next = 1'b0;
                        if ((req.page_count == '0) || (req.page_count > COUNT_MAX))
                        begin
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            iss_next       = '0;
                            run_next       = '0;
                            run_start_next = '0;
                            state_next     = ST_SCAN;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                // read one word ahead of the one being evaluated
                ev_valid_next = (iss_reg < (WADDR_W+1)'(MAP_WORDS));
                ev_word_next  = iss_reg[WADDR_W-1:0];
                if (iss_reg < (WADDR_W+1)'(MAP_WORDS))
                begin
                    iss_next = iss_reg + (WADDR_W+1)'(1);
                end
                if (ev_valid_reg)
                begin
                    if (scan.found)
                    begin
                        res_ok_next    = 1'b1;
                        res_start_next = scan.start;
                        lo_next        = scan.start;
                        hi_next        = alloc_end[PAGE_W-1:0];
                        iss_next       = {1'b0, scan.start[PAGE_W-1:BIT_W]};
                        last_next      = alloc_end[PAGE_W-1:BIT_W];
                        ev_valid_next  = 1'b0;
                        state_next     = ST_MARK;
                    end
                    else
                    begin
                        run_next       = scan.run;
                        run_start_next = scan.run_start;
                        if (ev_word_reg == WADDR_W'(MAP_WORDS - 1))
                        begin
                            // whole map seen, no run long enough
                            ev_valid_next = 1'b0;
                            state_next    = ST_RESP;
                        end
                    end
                end
            end

            ST_MARK:
            begin
                // read word n+1 while writing back word n
                if (iss_reg <= {1'b0, last_reg})
                begin
                    ev_valid_next = 1'b1;
                    ev_word_next  = iss_reg[WADDR_W-1:0];
                    iss_next      = iss_reg + (WADDR_W+1)'(1);
                end
                else
                begin
                    ev_valid_next = 1'b0;
                end
                if (ev_valid_reg)
                begin
                    ram_we = 1'b1;
                    if (ev_word_reg == last_reg)
                    begin
                        ev_valid_next = 1'b0;
                        state_next    = ST_RESP;
                    end
                end
            end

            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_ok_next    = res_ok_reg;
                    rsp_start_next = res_start_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            init_reg      <= '0;
            func_reg      <= 1'b0;
            count_reg     <= '0;
            iss_reg       <= '0;
            last_reg      <= '0;
            ev_valid_reg  <= 1'b0;
            ev_word_reg   <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            run_reg       <= '0;
            run_start_reg <= '0;
            res_ok_reg    <= 1'b0;
            res_start_reg <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_ok_reg    <= 1'b0;
            rsp_start_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            func_reg      <= func_next;
            count_reg     <= count_next;
            iss_reg       <= iss_next;
            last_reg      <= last_next;
            ev_valid_reg  <= ev_valid_next;
            ev_word_reg   <= ev_word_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            run_reg       <= run_next;
            run_start_reg <= run_start_next;
            res_ok_reg    <= res_ok_next;
            res_start_reg <= res_start_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_ok_reg    <= rsp_ok_next;
            rsp_start_reg <= rsp_start_next;
        end
    end

endmodule

>>> rtl/bpfa_ram.sv
module bpfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bpfa_scan.sv
module bpfa_scan (
    input  logic [bpfa_pkg::WORD_W-1:0]  word,
    input  logic [bpfa_pkg::WADDR_W-1:0] word_idx,
    input  logic [bpfa_pkg::COUNT_W-1:0] count,
    input  logic [bpfa_pkg::COUNT_W-1:0] run_in,
    input  logic [bpfa_pkg::PAGE_W-1:0]  run_start_in,
    output bpfa_pkg::scan_t              res
);
    import bpfa_pkg::*;

    logic [WORD_W-1:0]  free_bits;
    logic [BIT_W:0]     tz;
    logic [BIT_W:0]     lf;
    logic [WORD_W-1:0]  span [BIT_W];
    logic [WORD_W-1:0]  fit;
    logic [BIT_W-1:0]   pos;
    logic [BIT_W-1:0]   sh;
    logic [COUNT_W:0]   reach;
    logic [PAGE_W-1:0]  base;
    logic [BIT_W:0]     top_off;
    logic               short_req;

    always_comb
    begin
        free_bits = ~word;
        base      = {word_idx, {BIT_W{1'b0}}};
        short_req = (count < COUNT_W'(WORD_W));

        // free pages at the low end of the word
        tz = (BIT_W+1)'(WORD_W);
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!free_bits[i])
            begin
                tz = (BIT_W+1)'(i);
            end
        end

        // free pages at the high end of the word
        lf = (BIT_W+1)'(WORD_W);
        for (int i = 0; i < WORD_W; i++)
        begin
            if (!free_bits[i])
            begin
                lf = (BIT_W+1)'(WORD_W - 1 - i);
            end
        end

        // span[k] bit i: pages i .. i+2^k-1 all free
        span[0] = free_bits;
        for (int k = 1; k < BIT_W; k++)
        begin
            span[k] = span[k-1] & (span[k-1] >> (1 << (k - 1)));
        end

        // compose a run of exactly count from the binary digits of count
        fit = '1;
        for (int k = 0; k < BIT_W; k++)
        begin
            sh = count[BIT_W-1:0] & BIT_W'((1 << k) - 1);
            if (count[k])
            begin
                fit = fit & (span[k] >> sh);
            end
        end

        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (fit[i])
            begin
                pos = BIT_W'(i);
            end
        end

        reach   = {1'b0, run_in} + (COUNT_W+1)'(tz);
        top_off = (BIT_W+1)'(WORD_W) - lf;

        res.found     = 1'b0;
        res.start     = '0;
        res.run       = '0;
        res.run_start = base;

        if (reach >= {1'b0, count})
        begin
            // run carried from lower words (or starting here) completes
            res.found = 1'b1;
            res.start = (run_in == '0) ? base : run_start_in;
        end
        else if (short_req && (fit != '0))
        begin
            res.found = 1'b1;
            res.start = base | PAGE_W'(pos);
        end
        else if (tz == (BIT_W+1)'(WORD_W))
        begin
            res.run       = reach[COUNT_W-1:0];
            res.run_start = (run_in == '0) ? base : run_start_in;
        end
        else
        begin
            res.run       = COUNT_W'(lf);
            res.run_start = base | PAGE_W'(top_off[BIT_W-1:0]);
        end
    end

endmodule

>>> bench/bpfa_grant_checker.sv
module bpfa_grant_checker (
    input  logic clk,
    input  logic rst_n,
    bpfa_req_if  req,
    bpfa_rsp_if  rsp,
    output int   fail_count,
    output int   grants_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import bpfa_pkg::*;

    typedef struct packed
    {
        logic              ok;
        logic [PAGE_W-1:0] start_page;
    } grant_t;

    logic   frame_busy [PAGE_TOTAL];
    grant_t grant_q [$];
    int     n_fail = 0;

    // first-fit claim or release on the shadow map, returns the beat it owes
    function automatic grant_t claim_or_release(func_t f, logic [COUNT_W-1:0] n,
                                                logic [PAGE_W-1:0] fp);
        grant_t g;
        int     run;
        int     run_first;
        int     p;
        int     k;
        g         = '0;
        run       = 0;
        run_first = 0;
        if (f == FUNC_ALLOC)
        begin
            if (n != '0 && n <= COUNT_MAX)
            begin
                for (p = 0; p < PAGE_TOTAL && !g.ok; p++)
                begin
                    if (frame_busy[p])
                    begin
                        run = 0;
                    end
                    else
                    begin
                        if (run == 0)
                        begin
                            run_first = p;
                        end
                        run++;
                        if (run == int'(n))
                        begin
                            for (k = run_first; k <= p; k++)
                            begin
                                frame_busy[k] = 1'b1;
                            end
                            g.ok         = 1'b1;
                            g.start_page = PAGE_W'(run_first);
                        end
                    end
                end
            end
        end
        else
        begin
            for (k = 0; k < int'(n) && int'(fp) + k < PAGE_TOTAL; k++)
            begin
                frame_busy[int'(fp) + k] = 1'b0;
            end
            g.ok = 1'b1;
        end
        return g;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        grant_t want;
        int     p;
        if (!rst_n)
        begin
            for (p = 0; p < PAGE_TOTAL; p++)
            begin
                frame_busy[p] = (p < RES_LIM);
            end
            grant_q.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (grant_q.size() == 0)
                begin
                    n_fail++;
                    $display("%0t: unexpected beat ok=%0d start_page=%0d",
                             $realtime, rsp.ok, rsp.start_page);
                end
                else
                begin
                    want = grant_q.pop_front();
                    if (rsp.ok !== want.ok)
                    begin
                        n_fail++;
                        $display("%0t: ok expected %0d actual %0d",
                                 $realtime, want.ok, rsp.ok);
                    end
                    if (rsp.start_page !== want.start_page)
                    begin
                        n_fail++;
                        $display("%0t: start_page expected %0d actual %0d",
                                 $realtime, want.start_page, rsp.start_page);
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                grant_q.push_back(claim_or_release(func_t'(req.func), req.page_count,
                                                   req.first_page));
            end
        end
        fail_count  <= n_fail;
        grants_owed <= grant_q.size();
    end

endmodule

>>> bench/tb_bitmap_page_frame_allocator_core.sv
module tb_bitmap_page_frame_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bpfa_pkg::*;

    localparam int RANDOM_ITEMS = 850;
    // longest quiet stretch allowed: map clearing, a full scan and a full
    // read-modify-write pass, with plenty of margin
    localparam int STALL_LIMIT  = 4000;
    // settle time once nothing is owed, about one scan plus one write pass
    localparam int DRAIN_CYCLES = 300;

    // what was asked, kept until its beat comes back
    typedef struct packed
    {
        func_t              f;
        logic [COUNT_W-1:0] n;
    } ask_t;

    // a run of pages we believe we own, candidate for a later free
    typedef struct
    {
        int first;
        int count;
    } run_t;

    logic clk = 1'b0;
    logic rst_n;
    logic calm = 1'b0;
    int   fail_count;
    int   grants_owed;
    int   stall_cycles = 0;

    ask_t asked_q [$];
    run_t held_runs [$];

    bpfa_req_if req_ch ();
    bpfa_rsp_if rsp_ch ();

    bitmap_page_frame_allocator_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    bpfa_grant_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .fail_count  (fail_count),
        .grants_owed (grants_owed)
    );

    always #1 clk = ~clk;

    // response side back-pressure, none while calm
    always @(posedge clk)
    begin
        rsp_ch.ready <= calm || ($urandom_range(99) >= 9);
    end

    // collect granted runs so later frees can hand them back
    always @(posedge clk)
    begin
        ask_t a;
        if (rsp_ch.valid && rsp_ch.ready && asked_q.size() != 0)
        begin
            a = asked_q.pop_front();
            if (a.f == FUNC_ALLOC && rsp_ch.ok === 1'b1)
            begin
                held_runs.push_back('{int'(rsp_ch.start_page), int'(a.n)});
            end
        end
    end

    // watchdog: too long with no beat on either channel ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // one request beat, with random idle cycles in front unless calm
    task automatic send_request(func_t f, logic [COUNT_W-1:0] n, logic [PAGE_W-1:0] fp);
        while (!calm && $urandom_range(99) < 9)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.func       <= f;
        req_ch.page_count <= n;
        req_ch.first_page <= fp;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        asked_q.push_back('{f, n});
    endtask

    initial
    begin
        int   i;
        int   r;
        int   s;
        int   n;
        int   fp;
        int   idx;
        run_t hr;

        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.func       <= FUNC_ALLOC;
        req_ch.page_count <= '0;
        req_ch.first_page <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: failing allocates on the reserved map
        send_request(FUNC_ALLOC, 13'd0, 12'd0);        // zero count
        send_request(FUNC_ALLOC, 13'd4097, 12'd4095);  // just above the page total
        send_request(FUNC_ALLOC, 13'd8191, 12'd0);     // widest count
        send_request(FUNC_ALLOC, 13'd4096, 12'd0);     // whole map, blocked by reserved
        send_request(FUNC_ALLOC, 13'd3073, 12'd0);     // one more than is free
        // fill every free page, then ask again
        send_request(FUNC_ALLOC, 13'd1, 12'd0);
        send_request(FUNC_ALLOC, 13'd3071, 12'd0);
        send_request(FUNC_ALLOC, 13'd1, 12'd0);        // no run left
        // frees at the edges
        send_request(FUNC_FREE, 13'd0, 12'd2000);      // zero count free
        send_request(FUNC_FREE, 13'd8191, 12'd4095);   // past the end, last page only
        send_request(FUNC_ALLOC, 13'd1, 12'd0);        // lands on the last page
        send_request(FUNC_FREE, 13'd200, 12'd4000);    // runs off the end
        send_request(FUNC_FREE, 13'd96, 12'd4000);     // already free pages
        send_request(FUNC_ALLOC, 13'd96, 12'd0);
        // clear the reserved region too, then take the whole map
        send_request(FUNC_FREE, 13'd4096, 12'd0);
        send_request(FUNC_ALLOC, 13'd4096, 12'd0);
        send_request(FUNC_FREE, 13'd4096, 12'd0);
        // runs that straddle word boundaries and a hole too short to fit
        send_request(FUNC_ALLOC, 13'd33, 12'd0);
        send_request(FUNC_ALLOC, 13'd31, 12'd0);
        send_request(FUNC_FREE, 13'd5, 12'd10);
        send_request(FUNC_ALLOC, 13'd6, 12'd0);
        send_request(FUNC_ALLOC, 13'd5, 12'd0);
        // back to a reserved-like layout for the random part
        send_request(FUNC_FREE, 13'd4096, 12'd0);
        send_request(FUNC_ALLOC, 13'd1024, 12'd0);

        // random: mostly allocate / free pairs, some noise and full sweeps
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i >= 300 && i < 450);
            r    = $urandom_range(99);
            s    = $urandom_range(99);
            if (r >= 98)
            begin
                // sweep everything free, sometimes the reserved pages too
                held_runs.delete();
                if ($urandom_range(1) != 0)
                begin
                    send_request(FUNC_FREE, 13'd4096, 12'd0);
                end
                else
                begin
                    send_request(FUNC_FREE, 13'd3072, 12'd1024);
                end
            end
            else if (r >= 85)
            begin
                // free of an arbitrary range, may hit reserved or owned pages
                fp = $urandom_range(4095);
                n  = (s < 70) ? $urandom_range(64) : $urandom_range(8191);
                send_request(FUNC_FREE, COUNT_W'(n), PAGE_W'(fp));
            end
            else if (r < 45 || held_runs.size() == 0)
            begin
                // mostly small runs, a few large and a few illegal counts
                if (s < 60)
                begin
                    n = $urandom_range(16, 1);
                end
                else if (s < 85)
                begin
                    n = $urandom_range(256, 17);
                end
                else if (s < 95)
                begin
                    n = $urandom_range(3072, 257);
                end
                else if (s < 98)
                begin
                    n = $urandom_range(4096, 3073);
                end
                else
                begin
                    n = ($urandom_range(1) != 0) ? 0 : $urandom_range(8191, 4097);
                end
                // first_page is ignored on allocate, send junk in it
                send_request(FUNC_ALLOC, COUNT_W'(n), PAGE_W'($urandom));
            end
            else
            begin
                // give back a run we hold, now and then only a piece of it
                idx = $urandom_range(held_runs.size() - 1);
                hr  = held_runs[idx];
                held_runs.delete(idx);
                if (s < 80)
                begin
                    send_request(FUNC_FREE, COUNT_W'(hr.count), PAGE_W'(hr.first));
                end
                else
                begin
                    fp = hr.first + $urandom_range(hr.count - 1);
                    n  = $urandom_range(hr.first + hr.count - fp, 1);
                    send_request(FUNC_FREE, COUNT_W'(n), PAGE_W'(fp));
                end
            end
        end
        calm = 1'b0;
        req_ch.valid <= 1'b0;

        // let the owed count catch up with the last request beat
        @(posedge clk);

        // wait for every owed beat, then let the block settle
        while (grants_owed != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
